>>> rtl/p2p_pkg.sv
// Shared constants and width helpers for the point-to-plane distance block.
// Used by the front end, the back end and the top level; depends on nothing.
`default_nettype none

package p2p_pkg;

	// Width of the unsigned distance result.
	localparam int DIST_BITS = 33;

	// Signed width of one normal component (cross product of the edge vectors).
	function automatic int nrm_width(int cw);
		return 2 * (cw + 1) + 1;
	endfunction

	// Unsigned width of |n|^2.
	function automatic int nn_width(int cw);
		return 2 * nrm_width(cw);
	endfunction

	// Signed width of the dot product (p-a).n.
	function automatic int dot_width(int cw);
		return (cw + 1) + nrm_width(cw) + 2;
	endfunction

	// Limb width used to square the dot product in three pieces.
	function automatic int limb_width(int cw);
		return (dot_width(cw) + 2) / 3;
	endfunction

	// Width of the squared dot product.
	function automatic int dd_width(int cw);
		return 6 * limb_width(cw);
	endfunction

endpackage

`default_nettype wire

>>> rtl/point_to_plane_distance.sv
// Top level of the point-to-plane distance block.
// Instantiates p2p_front, p2p_back and two p2p_fifo queues; uses p2p_pkg.
`default_nettype none

// Streams one query per clock while full is low: each transaction gives a point
// and three plane points (signed fixed point, COORD_WIDTH bits) and returns
// floor(|(p-a).n|/|n|), saturated to 33 bits, with degenerate set and distance 0
// for collinear plane points. A transaction passes the front-end arithmetic, a
// queue, the 33-stage root search (one distance bit per stage) and the result
// queue. A 4-entry queue sits between the front and back pipelines and a 2-entry
// queue holds results, so a stalled consumer backs up the back end before it
// reaches the input.
module point_to_plane_distance #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic signed [COORD_WIDTH-1:0] point_x,
	input  wire logic signed [COORD_WIDTH-1:0] point_y,
	input  wire logic signed [COORD_WIDTH-1:0] point_z,
	input  wire logic signed [COORD_WIDTH-1:0] origin_x,
	input  wire logic signed [COORD_WIDTH-1:0] origin_y,
	input  wire logic signed [COORD_WIDTH-1:0] origin_z,
	input  wire logic signed [COORD_WIDTH-1:0] second_x,
	input  wire logic signed [COORD_WIDTH-1:0] second_y,
	input  wire logic signed [COORD_WIDTH-1:0] second_z,
	input  wire logic signed [COORD_WIDTH-1:0] third_x,
	input  wire logic signed [COORD_WIDTH-1:0] third_y,
	input  wire logic signed [COORD_WIDTH-1:0] third_z,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [p2p_pkg::DIST_BITS-1:0]      distance,
	output logic                               degenerate
);

	localparam int NNW = p2p_pkg::nn_width(COORD_WIDTH);
	localparam int DDW = p2p_pkg::dd_width(COORD_WIDTH);
	localparam int QB  = p2p_pkg::DIST_BITS;
	localparam int MW  = 1 + NNW + DDW;
	localparam int RW  = 1 + QB;

	logic signed [COORD_WIDTH-1:0] pt  [3];
	logic signed [COORD_WIDTH-1:0] org [3];
	logic signed [COORD_WIDTH-1:0] sec [3];
	logic signed [COORD_WIDTH-1:0] thd [3];

	logic           f_ready;
	logic           f_valid;
	logic [DDW-1:0] f_dd;
	logic [NNW-1:0] f_nn;
	logic           f_degen;
	logic           mq_full;
	logic           mq_empty;
	logic [MW-1:0]  mq_rdata;
	logic           b_ready;
	logic           b_valid;
	logic [QB-1:0]  b_dist;
	logic           b_degen;
	logic           rq_full;
	logic [RW-1:0]  rq_rdata;

	assign pt[0]  = point_x;
	assign pt[1]  = point_y;
	assign pt[2]  = point_z;
	assign org[0] = origin_x;
	assign org[1] = origin_y;
	assign org[2] = origin_z;
	assign sec[0] = second_x;
	assign sec[1] = second_y;
	assign sec[2] = second_z;
	assign thd[0] = third_x;
	assign thd[1] = third_y;
	assign thd[2] = third_z;

	assign full = !f_ready;

	p2p_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push),
		.in_ready  (f_ready),
		.pt        (pt),
		.org       (org),
		.sec       (sec),
		.thd       (thd),
		.out_valid (f_valid),
		.out_ready (!mq_full),
		.out_dd    (f_dd),
		.out_nn    (f_nn),
		.out_degen (f_degen)
	);

	p2p_fifo #(.WIDTH(MW), .DEPTH(4)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_valid),
		.wdata  ({f_degen, f_nn, f_dd}),
		.full   (mq_full),
		.pop    (b_ready),
		.rdata  (mq_rdata),
		.empty  (mq_empty)
	);

	p2p_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (!mq_empty),
		.in_ready     (b_ready),
		.in_dd        (mq_rdata[DDW-1:0]),
		.in_nn        (mq_rdata[DDW+NNW-1:DDW]),
		.in_degen     (mq_rdata[MW-1]),
		.out_valid    (b_valid),
		.out_ready    (!rq_full),
		.out_distance (b_dist),
		.out_degen    (b_degen)
	);

	p2p_fifo #(.WIDTH(RW), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (b_valid),
		.wdata  ({b_degen, b_dist}),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (rq_rdata),
		.empty  (empty)
	);

	assign distance   = rq_rdata[QB-1:0];
	assign degenerate = rq_rdata[RW-1];

endmodule

`default_nettype wire

>>> rtl/p2p_fifo.sv
// Small synchronous FIFO with full/empty flags.
// Used between front and back end and on the result side; no package use.
`default_nettype none

module p2p_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [AW:0]      cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

>>> rtl/p2p_front.sv
// Front end: edge vectors, normal, dot product, |n|^2, squared dot, degenerate flag.
// Ten-stage pipeline with wide multiplies split into limbs; uses p2p_pkg.
`default_nettype none

module p2p_front #(
	parameter int COORD_WIDTH = 32,
	localparam int NNW = p2p_pkg::nn_width(COORD_WIDTH),
	localparam int DDW = p2p_pkg::dd_width(COORD_WIDTH)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] pt  [3],
	input  wire logic signed [COORD_WIDTH-1:0] org [3],
	input  wire logic signed [COORD_WIDTH-1:0] sec [3],
	input  wire logic signed [COORD_WIDTH-1:0] thd [3],
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic             [DDW-1:0]         out_dd,
	output logic             [NNW-1:0]         out_nn,
	output logic                               out_degen
);

	localparam int DW   = COORD_WIDTH + 1;
	localparam int PW   = 2 * DW;
	localparam int NW   = p2p_pkg::nrm_width(COORD_WIDTH);
	localparam int LW   = (NW + 1) / 2;
	localparam int HW   = NW - LW;
	localparam int DOTW = p2p_pkg::dot_width(COORD_WIDTH);
	localparam int AL   = p2p_pkg::limb_width(COORD_WIDTH);
	localparam int MPW  = 3 * AL;
	localparam int SW   = NNW + 1;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	logic signed [DW-1:0]      e1_s1 [3];
	logic signed [DW-1:0]      e2_s1 [3];
	logic signed [DW-1:0]      w_s1  [3];
	logic signed [PW-1:0]      p_s2  [6];
	logic signed [DW-1:0]      w_s2  [3];
	logic signed [NW-1:0]      n_s3  [3];
	logic signed [DW-1:0]      w_s3  [3];
	logic signed [DW+LW:0]     wl_s4 [3];
	logic signed [DW+HW-1:0]   wh_s4 [3];
	logic signed [2*HW-1:0]    hh_s4 [3];
	logic signed [HW+LW:0]     hl_s4 [3];
	logic        [2*LW-1:0]    ll_s4 [3];
	logic signed [DOTW-1:0]    dotc_s5 [3];
	logic        [NNW-1:0]     nnc_s5  [3];
	logic signed [DOTW-1:0]    dot_s6;
	logic        [NNW-1:0]     nn_s6;
	logic        [MPW-1:0]     mag_s7;
	logic        [NNW-1:0]     nn_s7;
	logic                      dg_s7;
	logic        [2*AL-1:0]    m_s8 [6];
	logic        [NNW-1:0]     nn_s8;
	logic                      dg_s8;
	logic        [DDW-1:0]     a_s9;
	logic        [DDW-1:0]     b_s9;
	logic        [NNW-1:0]     nn_s9;
	logic                      dg_s9;
	logic        [DDW-1:0]     dd_s10;
	logic        [NNW-1:0]     nn_s10;
	logic                      dg_s10;

	logic        [LW-1:0]      nl  [3];
	logic signed [HW-1:0]      nh  [3];
	logic signed [LW:0]        nls [3];
	logic signed [SW-1:0]      nnt [3];
	logic        [DOTW-1:0]    absd;
	logic        [AL-1:0]      a0, a1, a2;

	assign en        = !v_s10 || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s10;
	assign out_dd    = dd_s10;
	assign out_nn    = nn_s10;
	assign out_degen = dg_s10;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nl[i]  = n_s3[i][LW-1:0];
			nh[i]  = $signed(n_s3[i][NW-1:LW]);
			nls[i] = $signed({1'b0, nl[i]});
			nnt[i] = (SW'(hh_s4[i]) <<< (2 * LW)) + (SW'(hl_s4[i]) <<< (LW + 1))
				+ $signed(SW'(ll_s4[i]));
		end
		absd = dot_s6[DOTW-1] ? $unsigned(-dot_s6) : $unsigned(dot_s6);
		a0 = mag_s7[AL-1:0];
		a1 = mag_s7[2*AL-1:AL];
		a2 = mag_s7[3*AL-1:2*AL];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= DW'(sec[i]) - DW'(org[i]);
				e2_s1[i] <= DW'(thd[i]) - DW'(org[i]);
				w_s1[i]  <= DW'(pt[i]) - DW'(org[i]);
			end

			// cross product terms
			p_s2[0] <= e1_s1[1] * e2_s1[2];
			p_s2[1] <= e2_s1[1] * e1_s1[2];
			p_s2[2] <= e1_s1[2] * e2_s1[0];
			p_s2[3] <= e1_s1[0] * e2_s1[2];
			p_s2[4] <= e1_s1[0] * e2_s1[1];
			p_s2[5] <= e2_s1[0] * e1_s1[1];
			w_s2    <= w_s1;

			n_s3[0] <= NW'(p_s2[0]) - NW'(p_s2[1]);
			n_s3[1] <= NW'(p_s2[2]) - NW'(p_s2[3]);
			n_s3[2] <= NW'(p_s2[4]) - NW'(p_s2[5]);
			w_s3    <= w_s2;

			// n split into signed high limb and unsigned low limb
			for (int i = 0; i < 3; i++) begin
				wl_s4[i] <= w_s3[i] * nls[i];
				wh_s4[i] <= w_s3[i] * nh[i];
				hh_s4[i] <= nh[i] * nh[i];
				hl_s4[i] <= nh[i] * nls[i];
				ll_s4[i] <= nl[i] * nl[i];
			end

			for (int i = 0; i < 3; i++) begin
				dotc_s5[i] <= (DOTW'(wh_s4[i]) <<< LW) + DOTW'(wl_s4[i]);
				nnc_s5[i]  <= nnt[i][NNW-1:0];
			end

			dot_s6 <= dotc_s5[0] + dotc_s5[1] + dotc_s5[2];
			nn_s6  <= nnc_s5[0] + nnc_s5[1] + nnc_s5[2];

			mag_s7 <= MPW'(absd);
			nn_s7  <= nn_s6;
			dg_s7  <= (nn_s6 == '0);

			m_s8[0] <= a0 * a0;
			m_s8[1] <= a0 * a1;
			m_s8[2] <= a0 * a2;
			m_s8[3] <= a1 * a1;
			m_s8[4] <= a1 * a2;
			m_s8[5] <= a2 * a2;
			nn_s8   <= nn_s7;
			dg_s8   <= dg_s7;

			a_s9  <= DDW'(m_s8[0]) + (DDW'(m_s8[1]) << (AL + 1))
				+ (DDW'(m_s8[3]) << (2 * AL));
			b_s9  <= (DDW'(m_s8[2]) << (2 * AL + 1)) + (DDW'(m_s8[4]) << (3 * AL + 1))
				+ (DDW'(m_s8[5]) << (4 * AL));
			nn_s9 <= nn_s8;
			dg_s9 <= dg_s8;

			dd_s10 <= a_s9 + b_s9;
			nn_s10 <= nn_s9;
			dg_s10 <= dg_s9;
		end
	end

endmodule

`default_nettype wire

>>> rtl/p2p_back.sv
// Back end: finds the largest q with q*q*nn <= dd, one result bit per stage.
// DIST_BITS-stage pipeline; uses p2p_pkg for widths.
`default_nettype none

module p2p_back #(
	parameter int COORD_WIDTH = 32,
	localparam int NNW = p2p_pkg::nn_width(COORD_WIDTH),
	localparam int DDW = p2p_pkg::dd_width(COORD_WIDTH),
	localparam int QB  = p2p_pkg::DIST_BITS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [DDW-1:0] in_dd,
	input  wire logic [NNW-1:0] in_nn,
	input  wire logic           in_degen,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic      [QB-1:0]  out_distance,
	output logic                out_degen
);

	localparam int AW  = QB + NNW;
	localparam int TX  = NNW + 2 * QB + 1;
	localparam int CPW = (DDW > TX) ? DDW : TX;

	logic en;

	// rem = dd - q^2*nn, acc = q*nn
	logic           v_s   [QB];
	logic [DDW-1:0] rem_s [QB];
	logic [AW-1:0]  acc_s [QB];
	logic [NNW-1:0] nn_s  [QB];
	logic [QB-1:0]  q_s   [QB];
	logic           dg_s  [QB];

	assign en           = !v_s[QB-1] || out_ready;
	assign in_ready     = en;
	assign out_valid    = v_s[QB-1];
	assign out_degen    = dg_s[QB-1];
	assign out_distance = dg_s[QB-1] ? '0 : q_s[QB-1];

	for (genvar j = 0; j < QB; j++) begin : g_stage
		localparam int K = QB - 1 - j;

		logic           v_i;
		logic [DDW-1:0] rem_i;
		logic [AW-1:0]  acc_i;
		logic [NNW-1:0] nn_i;
		logic [QB-1:0]  q_i;
		logic           dg_i;
		logic [CPW-1:0] t;
		logic           fits;

		if (j == 0) begin : g_first
			assign v_i   = in_valid;
			assign rem_i = in_dd;
			assign acc_i = '0;
			assign nn_i  = in_nn;
			assign q_i   = '0;
			assign dg_i  = in_degen;
		end else begin : g_next
			assign v_i   = v_s[j-1];
			assign rem_i = rem_s[j-1];
			assign acc_i = acc_s[j-1];
			assign nn_i  = nn_s[j-1];
			assign q_i   = q_s[j-1];
			assign dg_i  = dg_s[j-1];
		end

		// (q + 2^K)^2*nn - q^2*nn = 2^(K+1)*acc + 2^(2K)*nn
		assign t    = (CPW'(acc_i) << (K + 1)) + (CPW'(nn_i) << (2 * K));
		assign fits = (t <= CPW'(rem_i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= fits ? rem_i - t[DDW-1:0] : rem_i;
				acc_s[j] <= fits ? acc_i + (AW'(nn_i) << K) : acc_i;
				q_s[j]   <= fits ? (q_i | (QB'(1) << K)) : q_i;
				nn_s[j]  <= nn_i;
				dg_s[j]  <= dg_i;
			end
		end
	end

endmodule

`default_nettype wire
